// ===== rtl/fdp_pkg.sv =====
// Shared types and constants for the format directive parser.
// Depends on nothing; every other file refers to it by scoped names.
package fdp_pkg;

    // Operation kinds carried in op_kind.
    localparam logic [3:0] KIND_LIT    = 4'd0;
    localparam logic [3:0] KIND_S      = 4'd1;
    localparam logic [3:0] KIND_D      = 4'd2;
    localparam logic [3:0] KIND_F      = 4'd3;
    localparam logic [3:0] KIND_E      = 4'd4;
    localparam logic [3:0] KIND_B      = 4'd5;
    localparam logic [3:0] KIND_O      = 4'd6;
    localparam logic [3:0] KIND_XL     = 4'd7;
    localparam logic [3:0] KIND_XU     = 4'd8;
    localparam logic [3:0] KIND_STATUS = 4'd9;
    localparam logic [3:0] KIND_NONE   = 4'd0;

    // Status codes carried in status_code.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNEXP_END = 3'd1;
    localparam logic [2:0] ST_NO_PREC   = 3'd2;
    localparam logic [2:0] ST_CONVERT   = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_XL      = 8'h78;
    localparam logic [7:0] CH_XU      = 8'h58;

    localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;
    localparam logic [15:0] MAX_PREC_RESET = 16'd1000;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [4:0] {
        PH_LIT = 5'b00001,
        PH_PCT = 5'b00010,
        PH_DOT = 5'b00100,
        PH_DIG = 5'b01000,
        PH_ERR = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] offset;
        logic [16:0] length;
        logic        has_prec;
        logic [15:0] prec_val;
        logic [2:0]  status;
        logic [7:0]  bad_byte;
        logic        eos;
    } result_t;

    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_S:    k = KIND_S;
            CH_D:    k = KIND_D;
            CH_F:    k = KIND_F;
            CH_E:    k = KIND_E;
            CH_B:    k = KIND_B;
            CH_O:    k = KIND_O;
            CH_XL:   k = KIND_XL;
            CH_XU:   k = KIND_XU;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/fdp_parse.sv =====
// Parser state and per-byte decode: from one registered byte it forms up to two
// result items. Depends on fdp_pkg.
module fdp_parse #(
    parameter int MAX_STRING_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    input  logic [15:0]       max_prec,
    output fdp_pkg::result_t  res0,
    output fdp_pkg::result_t  res1,
    output logic [1:0]        res_count
);

    localparam int POS_W = (MAX_STRING_BYTES > 2) ? $clog2(MAX_STRING_BYTES) : 1;
    localparam int LEN_W = $clog2(MAX_STRING_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_STRING_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_STRING_BYTES);

    fdp_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [POS_W-1:0] dstart_reg, dstart_next;
    logic [30:0]      acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       err_reg, err_next;
    logic [7:0]       errb_reg, errb_next;

    logic             a_valid;
    fdp_pkg::result_t a_item, st_item;
    logic [3:0]       kind;
    logic             is_digit;
    logic [34:0]      acc_mul;
    logic [LEN_W-1:0] dir_len;

    always_comb
    begin
        kind     = fdp_pkg::classify(byte_in);
        is_digit = (byte_in >= fdp_pkg::CH_ZERO) && (byte_in <= fdp_pkg::CH_NINE);
        acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                 + {31'd0, 4'(byte_in - fdp_pkg::CH_ZERO)};
        dir_len  = LEN_W'(pos_reg) - LEN_W'(dstart_reg) + LEN_W'(1);

        phase_next     = phase_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        dstart_next    = dstart_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        err_next       = err_reg;
        errb_next      = errb_reg;
        a_valid        = 1'b0;
        a_item         = '0;

        unique case (phase_reg) inside
            fdp_pkg::PH_LIT:
            begin
                if (byte_in != fdp_pkg::CH_PERCENT)
                begin
                    if (run_len_reg == '0)
                    begin
                        run_start_next = pos_reg;
                        run_len_next   = LEN_W'(1);
                    end
                    else if (run_len_reg < LEN_MAX)
                    begin
                        run_len_next = run_len_reg + LEN_W'(1);
                    end
                    if (last_in)
                    begin
                        a_valid       = 1'b1;
                        a_item.kind   = fdp_pkg::KIND_LIT;
                        a_item.offset = 16'(run_start_next);
                        a_item.length = 17'(run_len_next);
                    end
                end
                else
                begin
                    if (run_len_reg != '0)
                    begin
                        a_valid       = 1'b1;
                        a_item.kind   = fdp_pkg::KIND_LIT;
                        a_item.offset = 16'(run_start_reg);
                        a_item.length = 17'(run_len_reg);
                    end
                    run_len_next = '0;
                    dstart_next  = pos_reg;
                    phase_next   = fdp_pkg::PH_PCT;
                    if (last_in)
                    begin
                        err_next   = fdp_pkg::ST_UNEXP_END;
                        errb_next  = 8'd0;
                        phase_next = fdp_pkg::PH_ERR;
                    end
                end
            end
            fdp_pkg::PH_PCT:
            begin
                if (byte_in == fdp_pkg::CH_PERCENT)
                begin
                    // The second percent opens a fresh literal span.
                    run_start_next = pos_reg;
                    run_len_next   = LEN_W'(1);
                    phase_next     = fdp_pkg::PH_LIT;
                    if (last_in)
                    begin
                        a_valid       = 1'b1;
                        a_item.kind   = fdp_pkg::KIND_LIT;
                        a_item.offset = 16'(pos_reg);
                        a_item.length = 17'd1;
                    end
                end
                else if (byte_in == fdp_pkg::CH_DOT)
                begin
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    phase_next = fdp_pkg::PH_DOT;
                    if (last_in)
                    begin
                        err_next   = fdp_pkg::ST_NO_PREC;
                        errb_next  = 8'd0;
                        phase_next = fdp_pkg::PH_ERR;
                    end
                end
                else if (kind == fdp_pkg::KIND_NONE)
                begin
                    err_next   = fdp_pkg::ST_BAD_TYPE;
                    errb_next  = byte_in;
                    phase_next = fdp_pkg::PH_ERR;
                end
                else
                begin
                    a_valid       = 1'b1;
                    a_item.kind   = kind;
                    a_item.offset = 16'(dstart_reg);
                    a_item.length = 17'(dir_len);
                    phase_next    = fdp_pkg::PH_LIT;
                end
            end
            fdp_pkg::PH_DOT, fdp_pkg::PH_DIG:
            begin
                if (is_digit)
                begin
                    // Saturating precision accumulate; overflow is remembered.
                    if (acc_mul > {4'd0, fdp_pkg::INT_LIMIT})
                    begin
                        ovf_next = 1'b1;
                        acc_next = fdp_pkg::INT_LIMIT;
                    end
                    else
                    begin
                        acc_next = acc_mul[30:0];
                    end
                    phase_next = fdp_pkg::PH_DIG;
                    if (last_in)
                    begin
                        err_next   = fdp_pkg::ST_NO_PREC;
                        errb_next  = 8'd0;
                        phase_next = fdp_pkg::PH_ERR;
                    end
                end
                else if (phase_reg == fdp_pkg::PH_DOT)
                begin
                    err_next   = fdp_pkg::ST_NO_PREC;
                    errb_next  = 8'd0;
                    phase_next = fdp_pkg::PH_ERR;
                end
                else if (ovf_reg)
                begin
                    err_next   = fdp_pkg::ST_CONVERT;
                    errb_next  = 8'd0;
                    phase_next = fdp_pkg::PH_ERR;
                end
                else if (acc_reg > {15'd0, max_prec})
                begin
                    err_next   = fdp_pkg::ST_TOO_LARGE;
                    errb_next  = 8'd0;
                    phase_next = fdp_pkg::PH_ERR;
                end
                else if (kind == fdp_pkg::KIND_NONE)
                begin
                    err_next   = fdp_pkg::ST_BAD_TYPE;
                    errb_next  = byte_in;
                    phase_next = fdp_pkg::PH_ERR;
                end
                else
                begin
                    a_valid       = 1'b1;
                    a_item.kind   = kind;
                    a_item.offset = 16'(dstart_reg);
                    a_item.length = 17'(dir_len);
                    if (kind == fdp_pkg::KIND_F || kind == fdp_pkg::KIND_E)
                    begin
                        a_item.has_prec = 1'b1;
                        a_item.prec_val = acc_reg[15:0];
                    end
                    phase_next = fdp_pkg::PH_LIT;
                end
            end
            fdp_pkg::PH_ERR:
            begin
                phase_next = fdp_pkg::PH_ERR;
            end
            default:
            begin
                phase_next = fdp_pkg::PH_ERR;
            end
        endcase

        st_item      = '0;
        st_item.kind = fdp_pkg::KIND_STATUS;
        st_item.eos  = 1'b1;
        if (phase_next == fdp_pkg::PH_ERR)
        begin
            st_item.status   = err_next;
            st_item.bad_byte = errb_next;
        end

        pos_next = pos_reg;
        if (last_in)
        begin
            // The string is closed: all parser state starts over.
            phase_next     = fdp_pkg::PH_LIT;
            pos_next       = '0;
            run_start_next = '0;
            run_len_next   = '0;
            dstart_next    = '0;
            acc_next       = '0;
            ovf_next       = 1'b0;
            err_next       = fdp_pkg::ST_OK;
            errb_next      = 8'd0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (a_valid)
        begin
            res0 = a_item;
        end
        else
        begin
            res0 = st_item;
        end
        res1 = st_item;
        if (!fire)
        begin
            res_count = 2'd0;
        end
        else
        begin
            res_count = {1'b0, a_valid} + {1'b0, last_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fdp_pkg::PH_LIT;
            pos_reg       <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            dstart_reg    <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            err_reg       <= fdp_pkg::ST_OK;
            errb_reg      <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            dstart_reg    <= dstart_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            err_reg       <= err_next;
            errb_reg      <= errb_next;
        end
    end

endmodule

// ===== rtl/fdp_out_queue.sv =====
// Small result queue: takes up to two items a cycle, gives one a cycle while out_ready is high.
// Depends on fdp_pkg.
module fdp_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  fdp_pkg::result_t  push0,
    input  fdp_pkg::result_t  push1,
    output logic              room2,
    output logic              out_valid,
    input  logic              out_ready,
    output fdp_pkg::result_t  head
);

    fdp_pkg::result_t mem_reg [fdp_pkg::Q_DEPTH];
    logic [fdp_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fdp_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fdp_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                        pop;
    logic [fdp_pkg::Q_CNT_W-1:0] free_after;

    always_comb
    begin
        pop         = out_valid && out_ready;
        free_after  = fdp_pkg::Q_CNT_W'(fdp_pkg::Q_DEPTH) - count_reg
                    + fdp_pkg::Q_CNT_W'(pop);
        room2       = free_after >= fdp_pkg::Q_CNT_W'(2);
        wr_ptr_next = wr_ptr_reg + fdp_pkg::Q_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + fdp_pkg::Q_PTR_W'(pop);
        count_next  = count_reg + fdp_pkg::Q_CNT_W'(push_count)
                    - fdp_pkg::Q_CNT_W'(pop);
        out_valid   = count_reg != '0;
        head        = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + fdp_pkg::Q_PTR_W'(1)] <= push1;
        end
    end

endmodule

// ===== rtl/format_directive_parser_top.sv =====
// Top level of the format directive parser: input register, parser, result queue.
// Depends on fdp_pkg, fdp_parse and fdp_out_queue.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid / in_ready   | byte_value, is_last
//   output  | out_valid / out_ready | op_kind .. end_of_string
//   config  | cfg_valid / cfg_ready | max_precision
//
// A byte is taken every cycle while the input register is empty or advancing. It is
// decoded from the input register, and its results enter the queue when the register
// advances; the queue then offers the first result on the output port.
// A byte makes up to two results, and the one-item-a-cycle output port then sets
// the sustained rate. The input register stalls while the queue lacks room for two.
// Reset clears the parser state, the queue and max_precision (to 1000).
module format_directive_parser_top #(
    parameter int MAX_STRING_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  op_kind,
    output logic [15:0] op_offset,
    output logic [16:0] op_length,
    output logic        has_precision,
    output logic [15:0] precision_value,
    output logic [2:0]  status_code,
    output logic [7:0]  bad_type_byte,
    output logic        end_of_string,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_precision
);

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;
    logic [15:0]      max_prec_reg;
    logic             room2;
    logic             advance;
    logic [1:0]       res_count;
    fdp_pkg::result_t res0, res1, head;

    assign advance   = s1_valid_reg && room2;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            max_prec_reg <= fdp_pkg::MAX_PREC_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (cfg_valid)
            begin
                max_prec_reg <= max_precision;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= byte_value;
            s1_last_reg <= is_last;
        end
    end

    fdp_parse #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .byte_in   (s1_byte_reg),
        .last_in   (s1_last_reg),
        .max_prec  (max_prec_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    fdp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign op_kind         = head.kind;
    assign op_offset       = head.offset;
    assign op_length       = head.length;
    assign has_precision   = head.has_prec;
    assign precision_value = head.prec_val;
    assign status_code     = head.status;
    assign bad_type_byte   = head.bad_byte;
    assign end_of_string   = head.eos;

endmodule

// ===== rtl/fdp_checker.sv =====
// Port-level checks for the format directive parser, bound to the top level.
// Depends on fdp_pkg and format_directive_parser_top.
module fdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  op_kind,
    input logic [15:0] op_offset,
    input logic [16:0] op_length,
    input logic        has_precision,
    input logic [2:0]  status_code,
    input logic        end_of_string
);

    // A result that is waiting keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op_kind)
            && $stable(op_offset) && $stable(op_length))
        else $error("result changed while stalled");

    // Only the closing status item marks the end of a string.
    a_eos_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> op_kind == fdp_pkg::KIND_STATUS)
        else $error("end of string on a non-status item");

    // Operations carry no status code and never end the string.
    a_op_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_kind != fdp_pkg::KIND_STATUS
            |-> status_code == fdp_pkg::ST_OK && !end_of_string)
        else $error("status fields set on an operation");

    // Precision is reported for f and e directives alone.
    a_prec_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_precision
            |-> op_kind == fdp_pkg::KIND_F || op_kind == fdp_pkg::KIND_E)
        else $error("precision on a kind other than f or e");

endmodule

bind format_directive_parser_top fdp_checker u_fdp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .op_kind       (op_kind),
    .op_offset     (op_offset),
    .op_length     (op_length),
    .has_precision (has_precision),
    .status_code   (status_code),
    .end_of_string (end_of_string)
);

// ===== tb/format_directive_parser_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for format_directive_parser_top: drives format strings byte by
// byte, predicts every literal, directive and status item, and checks the result stream.
// Depends on fdp_pkg and the format_directive_parser_top RTL only.
module format_directive_parser_top_tb;

    localparam int STRING_BYTES  = 65536;
    localparam int RANDOM_BYTES  = 500;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [7:0] TYPE_CHARS [8] = '{fdp_pkg::CH_S, fdp_pkg::CH_D, fdp_pkg::CH_F,
                                              fdp_pkg::CH_E, fdp_pkg::CH_B, fdp_pkg::CH_O,
                                              fdp_pkg::CH_XL, fdp_pkg::CH_XU};

    typedef logic [7:0] text_t[$];

    // Keeps its own copy of the parser state and the queue of items still owed by the block.
    class op_scoreboard;
        fdp_pkg::result_t pending_ops[$];
        int               mismatches;
        logic [15:0]      prec_limit;
        fdp_pkg::phase_t  phase;
        logic [15:0]      pos;
        logic [15:0]      run_start;
        logic [16:0]      run_len;
        logic [15:0]      dir_start;
        logic [31:0]      prec_acc;
        logic             prec_ovf;
        logic [2:0]       err_code;
        logic [7:0]       err_byte;

        function new();
            mismatches = 0;
            prec_limit = fdp_pkg::MAX_PREC_RESET;
            clear_string();
        endfunction

        function void clear_string();
            phase     = fdp_pkg::PH_LIT;
            pos       = '0;
            run_start = '0;
            run_len   = '0;
            dir_start = '0;
            prec_acc  = '0;
            prec_ovf  = 1'b0;
            err_code  = fdp_pkg::ST_OK;
            err_byte  = '0;
        endfunction

        function logic [3:0] kind_of(logic [7:0] b);
            case (b)
                fdp_pkg::CH_S:  return fdp_pkg::KIND_S;
                fdp_pkg::CH_D:  return fdp_pkg::KIND_D;
                fdp_pkg::CH_F:  return fdp_pkg::KIND_F;
                fdp_pkg::CH_E:  return fdp_pkg::KIND_E;
                fdp_pkg::CH_B:  return fdp_pkg::KIND_B;
                fdp_pkg::CH_O:  return fdp_pkg::KIND_O;
                fdp_pkg::CH_XL: return fdp_pkg::KIND_XL;
                fdp_pkg::CH_XU: return fdp_pkg::KIND_XU;
                default:        return fdp_pkg::KIND_NONE;
            endcase
        endfunction

        function void push_op(logic [3:0] kind, logic [15:0] off, logic [16:0] len,
                              logic hp, logic [15:0] pv, logic [2:0] st, logic [7:0] bb,
                              logic eos);
            fdp_pkg::result_t r;
            r.kind     = kind;
            r.offset   = off;
            r.length   = len;
            r.has_prec = hp;
            r.prec_val = pv;
            r.status   = st;
            r.bad_byte = bb;
            r.eos      = eos;
            pending_ops = {pending_ops, r};
        endfunction

        function void enter_error(logic [2:0] code, logic [7:0] b);
            err_code = code;
            err_byte = (code == fdp_pkg::ST_BAD_TYPE) ? b : 8'd0;
            phase    = fdp_pkg::PH_ERR;
        endfunction

        // Works out the items that one accepted byte causes.
        function void take_byte(logic [7:0] b, logic last);
            logic [15:0] cur;
            logic [63:0] acc;
            logic [3:0]  k;
            logic        fe;
            cur = pos;
            case (phase) inside
                fdp_pkg::PH_LIT:
                begin
                    if (b != fdp_pkg::CH_PERCENT)
                    begin
                        if (run_len == 0)
                        begin
                            run_start = cur;
                            run_len   = 17'd1;
                        end
                        else if (run_len < STRING_BYTES)
                        begin
                            run_len = run_len + 17'd1;
                        end
                        if (last)
                        begin
                            push_op(fdp_pkg::KIND_LIT, run_start, run_len, 1'b0, '0,
                                    fdp_pkg::ST_OK, '0, 1'b0);
                            run_len = '0;
                        end
                    end
                    else
                    begin
                        // A pending literal span is flushed as soon as a directive opens.
                        if (run_len != 0)
                            push_op(fdp_pkg::KIND_LIT, run_start, run_len, 1'b0, '0,
                                    fdp_pkg::ST_OK, '0, 1'b0);
                        run_len   = '0;
                        dir_start = cur;
                        phase     = fdp_pkg::PH_PCT;
                        if (last)
                            enter_error(fdp_pkg::ST_UNEXP_END, '0);
                    end
                end
                fdp_pkg::PH_PCT:
                begin
                    if (b == fdp_pkg::CH_PERCENT)
                    begin
                        // The second percent of a pair starts a fresh literal span.
                        run_start = cur;
                        run_len   = 17'd1;
                        phase     = fdp_pkg::PH_LIT;
                        if (last)
                        begin
                            push_op(fdp_pkg::KIND_LIT, run_start, run_len, 1'b0, '0,
                                    fdp_pkg::ST_OK, '0, 1'b0);
                            run_len = '0;
                        end
                    end
                    else if (b == fdp_pkg::CH_DOT)
                    begin
                        prec_acc = '0;
                        prec_ovf = 1'b0;
                        phase    = fdp_pkg::PH_DOT;
                        if (last)
                            enter_error(fdp_pkg::ST_NO_PREC, '0);
                    end
                    else
                    begin
                        k = kind_of(b);
                        if (k == fdp_pkg::KIND_NONE)
                        begin
                            enter_error(fdp_pkg::ST_BAD_TYPE, b);
                        end
                        else
                        begin
                            push_op(k, dir_start, {1'b0, cur} - {1'b0, dir_start} + 17'd1,
                                    1'b0, '0, fdp_pkg::ST_OK, '0, 1'b0);
                            phase = fdp_pkg::PH_LIT;
                        end
                    end
                end
                fdp_pkg::PH_DOT, fdp_pkg::PH_DIG:
                begin
                    if (b >= fdp_pkg::CH_ZERO && b <= fdp_pkg::CH_NINE)
                    begin
                        acc = 64'(prec_acc) * 64'd10 + 64'(b - fdp_pkg::CH_ZERO);
                        if (acc > 64'(fdp_pkg::INT_LIMIT))
                        begin
                            prec_ovf = 1'b1;
                            acc      = 64'(fdp_pkg::INT_LIMIT);
                        end
                        prec_acc = acc[31:0];
                        phase    = fdp_pkg::PH_DIG;
                        if (last)
                            enter_error(fdp_pkg::ST_NO_PREC, '0);
                    end
                    else if (phase == fdp_pkg::PH_DOT)
                    begin
                        enter_error(fdp_pkg::ST_NO_PREC, '0);
                    end
                    else if (prec_ovf)
                    begin
                        enter_error(fdp_pkg::ST_CONVERT, '0);
                    end
                    else if (prec_acc > {16'd0, prec_limit})
                    begin
                        enter_error(fdp_pkg::ST_TOO_LARGE, '0);
                    end
                    else
                    begin
                        k = kind_of(b);
                        if (k == fdp_pkg::KIND_NONE)
                        begin
                            enter_error(fdp_pkg::ST_BAD_TYPE, b);
                        end
                        else
                        begin
                            // Precision survives only on the floating-point types.
                            fe = (k == fdp_pkg::KIND_F || k == fdp_pkg::KIND_E);
                            push_op(k, dir_start, {1'b0, cur} - {1'b0, dir_start} + 17'd1,
                                    fe, fe ? prec_acc[15:0] : 16'd0, fdp_pkg::ST_OK, '0,
                                    1'b0);
                            phase = fdp_pkg::PH_LIT;
                        end
                    end
                end
                default:
                begin
                    phase = fdp_pkg::PH_ERR;
                end
            endcase

            if (last)
            begin
                push_op(fdp_pkg::KIND_STATUS, '0, '0, 1'b0, '0, err_code, err_byte, 1'b1);
                clear_string();
            end
            else if (pos < STRING_BYTES - 1)
            begin
                pos = pos + 16'd1;
            end
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_op(fdp_pkg::result_t got);
            fdp_pkg::result_t want;
            if (pending_ops.size() == 0)
            begin
                $error("op_kind %0d arrived with no item expected", got.kind);
                mismatches++;
                return;
            end
            want = pending_ops.pop_front();
            check_field("op_kind", want.kind, got.kind);
            check_field("op_offset", want.offset, got.offset);
            check_field("op_length", want.length, got.length);
            check_field("has_precision", want.has_prec, got.has_prec);
            check_field("precision_value", want.prec_val, got.prec_val);
            check_field("status_code", want.status, got.status);
            check_field("bad_type_byte", want.bad_byte, got.bad_byte);
            check_field("end_of_string", want.eos, got.eos);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = '0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  op_kind;
    logic [15:0] op_offset;
    logic [16:0] op_length;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [2:0]  status_code;
    logic [7:0]  bad_type_byte;
    logic        end_of_string;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] max_precision = '0;

    fdp_pkg::result_t seen_op;
    op_scoreboard     sb;
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;
    int               rx_hold_cycles = 0;

    assign seen_op = {op_kind, op_offset, op_length, has_precision, precision_value,
                      status_code, bad_type_byte, end_of_string};

    format_directive_parser_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_value      (byte_value),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .op_kind         (op_kind),
        .op_offset       (op_offset),
        .op_length       (op_length),
        .has_precision   (has_precision),
        .precision_value (precision_value),
        .status_code     (status_code),
        .bad_type_byte   (bad_type_byte),
        .end_of_string   (end_of_string),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_precision   (max_precision)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Handshakes are sampled at the edge with the values that decided them.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.take_byte(byte_value, is_last);
        if (cfg_valid && cfg_ready)
            sb.prec_limit = max_precision;
        if (out_valid && out_ready)
            sb.check_op(seen_op);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        is_last    <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input text_t text);
        int i;
        for (i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic send_str(input string s);
        text_t text;
        int    i;
        for (i = 0; i < s.len(); i++)
            text = {text, 8'(s[i])};
        send_text(text);
    endtask

    // Stops offering bytes and waits for every owed item, then lets the pipeline settle.
    task automatic quiesce();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_ops.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_prec_limit(input logic [15:0] v);
        quiesce();
        cfg_valid     <= 1'b1;
        max_precision <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] literal_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126))
                                            : 8'($urandom_range(0, 255));
        while (b == fdp_pkg::CH_PERCENT);
        return b;
    endfunction

    function automatic string precision_digits();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                v = int'(sb.prec_limit) + $urandom_range(0, 2) - 1;
            end
            1:
            begin
                v = $urandom_range(0, 70000);
            end
            2:
            begin
                // Eleven digits or more always overflow a signed 32-bit value.
                return $sformatf("%0d%0d", $urandom_range(100000, 999999),
                                 $urandom_range(10000, 99999));
            end
            3:
            begin
                return ($urandom_range(0, 1) == 0) ? "2147483647" : "2147483648";
            end
            default:
            begin
                v = $urandom_range(0, 20);
            end
        endcase
        if (v < 0)
            v = 0;
        return ($urandom_range(0, 9) == 0) ? $sformatf("0%0d", v) : $sformatf("%0d", v);
    endfunction

    function automatic text_t make_random_text();
        text_t text;
        string num;
        int    n;
        int    i;
        if ($urandom_range(0, 9) == 0)
        begin
            // Unstructured bytes, biased towards the characters the parser cares about.
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       text = {text, fdp_pkg::CH_PERCENT};
                    1:       text = {text, fdp_pkg::CH_DOT};
                    default: text = {text, 8'($urandom_range(0, 255))};
                endcase
            end
            return text;
        end
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9)) inside
                [0:3]:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) text = {text, literal_byte()};
                end
                4:
                begin
                    text = {text, fdp_pkg::CH_PERCENT, fdp_pkg::CH_PERCENT};
                end
                9:
                begin
                    text = {text, fdp_pkg::CH_PERCENT, fdp_pkg::CH_DOT,
                            8'($urandom_range(0, 255))};
                end
                default:
                begin
                    text = {text, fdp_pkg::CH_PERCENT};
                    if ($urandom_range(0, 1) == 0)
                    begin
                        text = {text, fdp_pkg::CH_DOT};
                        num = precision_digits();
                        for (i = 0; i < num.len(); i++)
                            text = {text, 8'(num[i])};
                    end
                    if ($urandom_range(0, 7) == 0)
                        text = {text, 8'($urandom_range(0, 255))};
                    else
                        text = {text, TYPE_CHARS[$urandom_range(0, 7)]};
                end
            endcase
        end
        // Now and then the string is cut short, often in the middle of a directive.
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, text.size());
            while (text.size() > n)
                void'(text.pop_back());
        end
        return text;
    endfunction

    // Output side: a random wait before each item, with occasional runs of no waiting and
    // one long hold-off when the stimulus asks for it.
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int    sent;
        int    strings;
        text_t text;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str("ab");
        send_str("%");
        send_str("x%");
        send_str("%%");
        send_str("%s%d%f%e%b%o%x%X");
        send_str("%.3f%.7d%.12e%.1000e");
        send_str("%.1001e");
        send_str("%.");
        send_str("%.x");
        send_str("%.12");
        send_str("%.99999999999f");
        send_str("%q");
        send_str("%.2qabc%d");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        write_prec_limit(16'd0);
        send_str("%.0f");
        send_str("%.1x");
        send_str("%.99999999999q");
        send_str("%.f");
        write_prec_limit(16'hFFFF);
        send_str("%.65535e");
        send_str("%.65536e");
        write_prec_limit(fdp_pkg::MAX_PREC_RESET);

        sent = 0;
        strings = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (strings % 40 == 39)
            begin
                case ($urandom_range(0, 4))
                    0:       write_prec_limit(16'd0);
                    1:       write_prec_limit(16'hFFFF);
                    2:       write_prec_limit(fdp_pkg::MAX_PREC_RESET);
                    3:       write_prec_limit(16'($urandom_range(0, 50)));
                    default: write_prec_limit(16'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(0, 14) == 0)
                quiesce();
            if (strings == 60)
            begin
                // Hold the output off while one-byte strings, two items each, pile up.
                rx_hold_cycles = 250;
                tx_burst = 1'b1;
                repeat (30) send_str("a");
                quiesce();
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            text = make_random_text();
            send_text(text);
            sent += text.size();
            strings++;
        end

        quiesce();
        if (sb.pending_ops.size() != 0)
            $error("%0d expected items never arrived", sb.pending_ops.size());
        if (sb.mismatches == 0 && sb.pending_ops.size() == 0)
            $display("PASS format_directive_parser_top");
        else
            $display("FAIL format_directive_parser_top");
        $finish;
    end

    // Far beyond the slowest correct run, which is well under a million nanoseconds.
    initial
    begin : watchdog
        #20000000;
        $display("FAIL format_directive_parser_top");
        $finish;
    end

endmodule
